### hw/rtl/saa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shelf atlas allocator package
// Payload types, codes, reset values and the side clamp shared by the block.
// ----------------------------------------------------------------------------
package saa_pkg;

	localparam int LOG2_W = 4;
	localparam int CFG_DATA_W = 4;
	localparam int CFG_INDEX_W = 1;

	localparam int LOG2_MAX_SIDE_DEF = 13;
	localparam int LOG2_MIN_SIDE_DEF = 6;
	localparam int RESERVED_BLOCK_DEF = 4;

	localparam logic [LOG2_W-1:0] CFG_INITIAL_RST = 4'd9;
	localparam logic [LOG2_W-1:0] CFG_MAX_RST = 4'd12;

	localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_SIDE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SIDE = 1'd1;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_TAKE = 1'b1;

	localparam logic [1:0] STATUS_PLACED = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_NONE = 2'd2;
	localparam logic [1:0] STATUS_REGION = 2'd3;

	typedef struct packed {
		logic        operation;
		logic [13:0] cell_width;
		logic [13:0] cell_height;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [12:0] cell_x;
		logic [12:0] cell_y;
		logic [12:0] region_x;
		logic [12:0] region_y;
		logic [13:0] region_w;
		logic [13:0] region_h;
		logic        was_resized;
		logic [13:0] atlas_side;
		logic        atlas_full;
	} rsp_t;

	function automatic logic [LOG2_W-1:0] clamp_log2(input logic [LOG2_W-1:0] v,
		input logic [LOG2_W-1:0] lo, input logic [LOG2_W-1:0] hi);
		logic [LOG2_W-1:0] r;
		r = v;
		if (r < lo) begin
			r = lo;
		end
		if (r > hi) begin
			r = hi;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/saa_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shelf atlas allocator arithmetic unit
// Shared adder and subtractor with a magnitude compare of the result.
// ----------------------------------------------------------------------------
module saa_alu #(
	parameter int W = 16
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	input  wire logic [W-1:0] c,
	input  wire logic         sub,
	output logic [W-1:0]      sum,
	output logic              gt
);

	assign sum = a + (sub ? ~b : b) + W'(sub);
	assign gt = sum > c;

endmodule
`default_nettype wire

### hw/rtl/shelf_atlas_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shelf atlas allocator
// Places cells in a square atlas by shelf packing and tracks the dirty region.
// ----------------------------------------------------------------------------
// Channel  Direction  Signals                        Transfer when
// req      in         req_valid, req_ready, req      req_valid && req_ready
// rsp      out        rsp_valid, rsp_ready, rsp      rsp_valid && rsp_ready
// cfg      in         cfg_we, cfg_index, cfg_data    cfg_we
//
// One item at a time; the steps of an item share the adder in saa_alu.
// A take shows its result in the cycle after the request transfer.
// An allocation passes fit-x, a new shelf when the row overruns, fit-y, place,
// the join states when the cell merges into an existing dirty box, and done;
// each atlas doubling goes back to fit-x, and a failure goes from fit-y to done.
// The request side stays stalled while a response waits to transfer.
// Reset brings up the atlas at the clamped initial side, wholly dirty.
// ----------------------------------------------------------------------------
module shelf_atlas_allocator #(
	parameter int LOG2_MAX_SIDE = saa_pkg::LOG2_MAX_SIDE_DEF,
	parameter int LOG2_MIN_SIDE = saa_pkg::LOG2_MIN_SIDE_DEF,
	parameter int RESERVED_BLOCK = saa_pkg::RESERVED_BLOCK_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output logic                                    req_ready,
	input  wire saa_pkg::req_t                      req,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_ready,
	output saa_pkg::rsp_t                           rsp,
	input  wire logic                               cfg_we,
	input  wire logic [saa_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [saa_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import saa_pkg::*;

	localparam int DW = ((LOG2_MAX_SIDE + 2 > 14) ? LOG2_MAX_SIDE + 2 : 14) + 1;
	localparam logic [LOG2_W-1:0] MIN_L = LOG2_W'(LOG2_MIN_SIDE);
	localparam logic [LOG2_W-1:0] MAX_L = LOG2_W'(LOG2_MAX_SIDE);
	localparam logic [LOG2_W-1:0] EFF_MAX_RST = clamp_log2(CFG_MAX_RST, MIN_L, MAX_L);
	localparam logic [LOG2_W-1:0] SIDE_RST = clamp_log2(CFG_INITIAL_RST, MIN_L, EFF_MAX_RST);
	localparam logic [DW-1:0] SIDE_LEN_RST = DW'(1) << SIDE_RST;
	localparam logic [DW-1:0] RESERVED = DW'(RESERVED_BLOCK);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIT_X,
		ST_NEW_SHELF,
		ST_FIT_Y,
		ST_PLACE,
		ST_JOIN_R0,
		ST_JOIN_R1,
		ST_JOIN_W,
		ST_JOIN_B0,
		ST_JOIN_B1,
		ST_JOIN_H,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [LOG2_W-1:0] max_side_q;
	logic [LOG2_W-1:0] side_log2_q;
	logic [DW-1:0]     shelf_x_q;
	logic [DW-1:0]     shelf_y_q;
	logic [DW-1:0]     shelf_h_q;
	logic              full_q;
	logic              resized_q;
	logic              dirty_q;
	logic [DW-1:0]     box_x_q;
	logic [DW-1:0]     box_y_q;
	logic [DW-1:0]     box_w_q;
	logic [DW-1:0]     box_h_q;
	logic [DW-1:0]     w_q;
	logic [DW-1:0]     h_q;
	logic [DW-1:0]     cx_q;
	logic [DW-1:0]     cy_q;
	logic [DW-1:0]     tmp_q;
	logic [1:0]        status_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [LOG2_W-1:0] eff_max;
	logic [LOG2_W-1:0] init_log2;
	logic [DW-1:0]     side_len;
	logic [DW-1:0]     min_x;
	logic [DW-1:0]     min_y;
	logic [DW-1:0]     alu_a;
	logic [DW-1:0]     alu_b;
	logic [DW-1:0]     alu_c;
	logic              alu_sub;
	logic [DW-1:0]     alu_sum;
	logic              alu_gt;

	assign eff_max = clamp_log2(max_side_q, MIN_L, MAX_L);
	assign init_log2 = clamp_log2(cfg_data, MIN_L, eff_max);
	assign side_len = DW'(1) << side_log2_q;
	assign min_x = (box_x_q < cx_q) ? box_x_q : cx_q;
	assign min_y = (box_y_q < cy_q) ? box_y_q : cy_q;

	always_comb begin
		alu_a = shelf_x_q;
		alu_b = w_q;
		alu_c = side_len;
		alu_sub = 1'b0;
		case (state_q)
			ST_NEW_SHELF: begin
				alu_a = shelf_y_q;
				alu_b = shelf_h_q;
			end
			ST_FIT_Y: begin
				alu_a = shelf_y_q;
				alu_b = h_q;
			end
			ST_JOIN_R0: begin
				alu_a = box_x_q;
				alu_b = box_w_q;
			end
			ST_JOIN_R1: begin
				alu_a = cx_q;
				alu_c = tmp_q;
			end
			ST_JOIN_W: begin
				alu_a = tmp_q;
				alu_b = min_x;
				alu_sub = 1'b1;
			end
			ST_JOIN_B0: begin
				alu_a = box_y_q;
				alu_b = box_h_q;
			end
			ST_JOIN_B1: begin
				alu_a = cy_q;
				alu_b = h_q;
				alu_c = tmp_q;
			end
			ST_JOIN_H: begin
				alu_a = tmp_q;
				alu_b = min_y;
				alu_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	saa_alu #(
		.W(DW)
	) u_alu (
		.a(alu_a),
		.b(alu_b),
		.c(alu_c),
		.sub(alu_sub),
		.sum(alu_sum),
		.gt(alu_gt)
	);

	assign req_ready = (state_q == ST_IDLE) && !rsp_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			max_side_q <= CFG_MAX_RST;
			side_log2_q <= SIDE_RST;
			shelf_x_q <= RESERVED;
			shelf_y_q <= '0;
			shelf_h_q <= RESERVED;
			full_q <= 1'b0;
			resized_q <= 1'b1;
			dirty_q <= 1'b1;
			box_x_q <= '0;
			box_y_q <= '0;
			box_w_q <= SIDE_LEN_RST;
			box_h_q <= SIDE_LEN_RST;
			w_q <= '0;
			h_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			tmp_q <= '0;
			status_q <= STATUS_PLACED;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_INITIAL_SIDE: begin
						side_log2_q <= init_log2;
						shelf_x_q <= RESERVED;
						shelf_y_q <= '0;
						shelf_h_q <= RESERVED;
						full_q <= 1'b0;
						resized_q <= 1'b1;
						dirty_q <= 1'b1;
						box_x_q <= '0;
						box_y_q <= '0;
						box_w_q <= DW'(1) << init_log2;
						box_h_q <= DW'(1) << init_log2;
					end
					CFG_MAX_SIDE: begin
						max_side_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid && req_ready) begin
						w_q <= DW'(req.cell_width);
						h_q <= DW'(req.cell_height);
						if (req.operation == OP_ALLOC) begin
							state_q <= ST_FIT_X;
						end else begin
							rsp_q.status <= (!resized_q && !dirty_q) ?
								STATUS_NONE : STATUS_REGION;
							rsp_q.cell_x <= '0;
							rsp_q.cell_y <= '0;
							rsp_q.region_x <= (dirty_q && !resized_q) ?
								box_x_q[12:0] : '0;
							rsp_q.region_y <= (dirty_q && !resized_q) ?
								box_y_q[12:0] : '0;
							rsp_q.region_w <= resized_q ? side_len[13:0] :
								(dirty_q ? box_w_q[13:0] : '0);
							rsp_q.region_h <= resized_q ? side_len[13:0] :
								(dirty_q ? box_h_q[13:0] : '0);
							rsp_q.was_resized <= resized_q;
							rsp_q.atlas_side <= side_len[13:0];
							rsp_q.atlas_full <= full_q;
							rsp_valid_q <= 1'b1;
							resized_q <= 1'b0;
							dirty_q <= 1'b0;
						end
					end
				end
				ST_FIT_X: begin
					state_q <= alu_gt ? ST_NEW_SHELF : ST_FIT_Y;
				end
				ST_NEW_SHELF: begin
					shelf_y_q <= alu_sum;
					shelf_x_q <= '0;
					shelf_h_q <= '0;
					state_q <= ST_FIT_Y;
				end
				ST_FIT_Y: begin
					if (alu_gt || (w_q > side_len)) begin
						if (side_log2_q >= eff_max) begin
							full_q <= 1'b1;
							status_q <= STATUS_FULL;
							state_q <= ST_DONE;
						end else begin
							side_log2_q <= side_log2_q + LOG2_W'(1);
							resized_q <= 1'b1;
							dirty_q <= 1'b1;
							box_x_q <= '0;
							box_y_q <= '0;
							box_w_q <= side_len << 1;
							box_h_q <= side_len << 1;
							state_q <= ST_FIT_X;
						end
					end else begin
						cx_q <= shelf_x_q;
						cy_q <= shelf_y_q;
						status_q <= STATUS_PLACED;
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					shelf_x_q <= alu_sum;
					if (h_q > shelf_h_q) begin
						shelf_h_q <= h_q;
					end
					if ((w_q == '0) || (h_q == '0)) begin
						state_q <= ST_DONE;
					end else if (!dirty_q) begin
						box_x_q <= cx_q;
						box_y_q <= cy_q;
						box_w_q <= w_q;
						box_h_q <= h_q;
						dirty_q <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_JOIN_R0;
					end
				end
				ST_JOIN_R0: begin
					tmp_q <= alu_sum;
					state_q <= ST_JOIN_R1;
				end
				ST_JOIN_R1: begin
					if (alu_gt) begin
						tmp_q <= alu_sum;
					end
					state_q <= ST_JOIN_W;
				end
				ST_JOIN_W: begin
					box_x_q <= min_x;
					box_w_q <= alu_sum;
					state_q <= ST_JOIN_B0;
				end
				ST_JOIN_B0: begin
					tmp_q <= alu_sum;
					state_q <= ST_JOIN_B1;
				end
				ST_JOIN_B1: begin
					if (alu_gt) begin
						tmp_q <= alu_sum;
					end
					state_q <= ST_JOIN_H;
				end
				ST_JOIN_H: begin
					box_y_q <= min_y;
					box_h_q <= alu_sum;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					rsp_q.status <= status_q;
					rsp_q.cell_x <= (status_q == STATUS_PLACED) ? cx_q[12:0] : '0;
					rsp_q.cell_y <= (status_q == STATUS_PLACED) ? cy_q[12:0] : '0;
					rsp_q.region_x <= '0;
					rsp_q.region_y <= '0;
					rsp_q.region_w <= '0;
					rsp_q.region_h <= '0;
					rsp_q.was_resized <= resized_q;
					rsp_q.atlas_side <= side_len[13:0];
					rsp_q.atlas_full <= full_q;
					rsp_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request side ready right after a transfer");

	a_full_status_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STATUS_FULL) |-> rsp.atlas_full)
		else $error("full status without the sticky full flag");

	a_none_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STATUS_NONE) |->
		(rsp.region_w == '0) && (rsp.region_h == '0) && !rsp.was_resized)
		else $error("empty take carries a region");

	a_side_at_least_min: assert property (@(posedge clk) disable iff (!arst_n)
		side_log2_q >= MIN_L)
		else $error("atlas side below the minimum");

endmodule
`default_nettype wire

### test/tb_shelf_atlas_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shelf atlas allocator testbench
// Drives allocate and take requests through the valid/ready channels, keeps
// its own copy of the shelf packing state and the dirty region, and compares
// every response field with the value that copy computes. Directed cases
// cover the field extremes and register limits; random phases follow, with
// varied idling on both channels, register changes while the block is idle,
// and one long response hold-off.
// ----------------------------------------------------------------------------
module tb_shelf_atlas_allocator;

	import saa_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int unsigned send_idle_pct;
	int unsigned rcv_stall_pct;
	int unsigned hold_len;
	int unsigned errors;
	int unsigned cycles;

	rsp_t replies_due[$];

	logic [LOG2_W-1:0] reg_initial;
	logic [LOG2_W-1:0] reg_max;
	logic [LOG2_W-1:0] at_log2;
	int unsigned at_x;
	int unsigned at_y;
	int unsigned at_shelf_h;
	bit at_full;
	bit at_resized;
	bit at_dirty;
	int unsigned dl;
	int unsigned dt;
	int unsigned dw;
	int unsigned dh;

	shelf_atlas_allocator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	function automatic logic [LOG2_W-1:0] max_side_eff();
		logic [LOG2_W-1:0] m;
		m = reg_max;
		if (m > LOG2_MAX_SIDE_DEF) begin
			m = LOG2_W'(LOG2_MAX_SIDE_DEF);
		end
		if (m < LOG2_MIN_SIDE_DEF) begin
			m = LOG2_W'(LOG2_MIN_SIDE_DEF);
		end
		return m;
	endfunction

	function automatic void mark_whole();
		at_resized = 1'b1;
		at_dirty = 1'b1;
		dl = 0;
		dt = 0;
		dw = 32'd1 << at_log2;
		dh = 32'd1 << at_log2;
	endfunction

	function automatic void init_atlas();
		logic [LOG2_W-1:0] mx;
		logic [LOG2_W-1:0] s;
		mx = max_side_eff();
		s = reg_initial;
		if (s < LOG2_MIN_SIDE_DEF) begin
			s = LOG2_W'(LOG2_MIN_SIDE_DEF);
		end
		if (s > mx) begin
			s = mx;
		end
		at_log2 = s;
		at_x = RESERVED_BLOCK_DEF;
		at_y = 0;
		at_shelf_h = RESERVED_BLOCK_DEF;
		at_full = 1'b0;
		mark_whole();
	endfunction

	// Places or takes as the block does and returns the response it must give.
	function automatic rsp_t pack_cell(input req_t item);
		rsp_t r;
		int unsigned w;
		int unsigned h;
		int unsigned side;
		int unsigned cx;
		int unsigned cy;
		int unsigned rgt;
		int unsigned bot;
		bit done;
		r = '0;
		done = 1'b0;
		w = 32'(item.cell_width);
		h = 32'(item.cell_height);
		if (item.operation == OP_ALLOC) begin
			r.status = STATUS_FULL;
			while (!done) begin
				side = 32'd1 << at_log2;
				if (at_x + w > side) begin
					at_y += at_shelf_h;
					at_x = 0;
					at_shelf_h = 0;
				end
				if (at_y + h > side || w > side) begin
					if (at_log2 >= max_side_eff()) begin
						at_full = 1'b1;
						done = 1'b1;
					end else begin
						at_log2++;
						mark_whole();
					end
				end else begin
					cx = at_x;
					cy = at_y;
					at_x += w;
					if (h > at_shelf_h) begin
						at_shelf_h = h;
					end
					if (w != 0 && h != 0) begin
						if (!at_dirty) begin
							dl = cx;
							dt = cy;
							dw = w;
							dh = h;
							at_dirty = 1'b1;
						end else begin
							rgt = (dl + dw > cx + w) ? dl + dw : cx + w;
							bot = (dt + dh > cy + h) ? dt + dh : cy + h;
							dl = (dl < cx) ? dl : cx;
							dt = (dt < cy) ? dt : cy;
							dw = rgt - dl;
							dh = bot - dt;
						end
					end
					r.status = STATUS_PLACED;
					r.cell_x = cx[12:0];
					r.cell_y = cy[12:0];
					done = 1'b1;
				end
			end
			r.was_resized = at_resized;
		end else if (!at_resized && !at_dirty) begin
			r.status = STATUS_NONE;
		end else begin
			r.status = STATUS_REGION;
			r.was_resized = at_resized;
			if (at_resized) begin
				side = 32'd1 << at_log2;
				r.region_w = side[13:0];
				r.region_h = side[13:0];
			end else begin
				r.region_x = dl[12:0];
				r.region_y = dt[12:0];
				r.region_w = dw[13:0];
				r.region_h = dh[13:0];
			end
			at_resized = 1'b0;
			at_dirty = 1'b0;
		end
		side = 32'd1 << at_log2;
		r.atlas_side = side[13:0];
		r.atlas_full = at_full;
		return r;
	endfunction

	task automatic report_error(input string msg);
		errors++;
		if (errors <= 50) begin
			$display("ERROR @%0t: %s", $realtime, msg);
		end
	endtask

	task automatic check_field(input string name, input logic [13:0] got,
		input logic [13:0] want);
		if (got !== want) begin
			report_error($sformatf("%s got %0d want %0d", name, got, want));
		end
	endtask

	task automatic send_item(input req_t item);
		rsp_t due;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!(req_valid && req_ready));
		due = pack_cell(item);
		replies_due.insert(replies_due.size(), due);
	endtask

	task automatic alloc(input int unsigned w, input int unsigned h);
		req_t item;
		item.operation = OP_ALLOC;
		item.cell_width = w[13:0];
		item.cell_height = h[13:0];
		send_item(item);
	endtask

	task automatic take();
		req_t item;
		item.operation = OP_TAKE;
		item.cell_width = 14'($urandom_range(16383));
		item.cell_height = 14'($urandom_range(16383));
		send_item(item);
	endtask

	task automatic wait_quiet();
		req_valid <= 1'b0;
		while (replies_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// The block is idle once every response has transferred.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		wait_quiet();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_INITIAL_SIDE) begin
			reg_initial = val;
			init_atlas();
		end else if (idx == CFG_MAX_SIDE) begin
			reg_max = val;
		end
		@(posedge clk);
	endtask

	function automatic int unsigned rand_extent();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 5) begin
			return 0;
		end else if (p < 55) begin
			return $urandom_range(24, 1);
		end else if (p < 80) begin
			return $urandom_range(256, 25);
		end else if (p < 95) begin
			return $urandom_range(2048, 257);
		end else if (p < 98) begin
			return $urandom_range(8191, 2049);
		end
		return 8192;
	endfunction

	task automatic test_reset_defaults();
		take();
		take();
		alloc(1, 1);
		take();
		alloc(0, 5);
		alloc(5, 0);
		take();
		alloc(8192, 1);
		take();
		alloc(1, 8192);
		alloc(4000, 4);
		take();
	endtask

	task automatic test_register_limits();
		write_reg(CFG_MAX_SIDE, 4'd15);
		write_reg(CFG_INITIAL_SIDE, 4'd15);
		alloc(8192, 8192);
		take();
		write_reg(CFG_INITIAL_SIDE, 4'd0);
		alloc(64, 64);
		take();
		write_reg(CFG_MAX_SIDE, 4'd0);
		alloc(128, 128);
		alloc(60, 60);
		take();
		write_reg(CFG_MAX_SIDE, 4'd13);
		write_reg(CFG_INITIAL_SIDE, 4'd13);
		alloc(8188, 4);
		alloc(1, 8188);
		take();
		write_reg(CFG_MAX_SIDE, 4'd6);
		write_reg(CFG_INITIAL_SIDE, 4'd6);
		for (int i = 0; i < 4; i++) begin
			alloc(30, 31);
		end
		take();
	endtask

	task automatic test_random_phase(input int unsigned items, input int unsigned idle_pct,
		input int unsigned stall_pct);
		req_t item;
		int unsigned sel;
		send_idle_pct = idle_pct;
		rcv_stall_pct = stall_pct;
		for (int unsigned i = 0; i < items; i++) begin
			if (i % 100 == 0) begin
				sel = $urandom_range(3);
				if (sel == 0 || sel == 2) begin
					write_reg(CFG_MAX_SIDE, ($urandom_range(1) != 0) ?
						4'($urandom_range(9, 6)) : 4'($urandom_range(15)));
				end
				if (sel <= 1) begin
					write_reg(CFG_INITIAL_SIDE, 4'($urandom_range(15)));
				end
			end
			if ($urandom_range(99) < 12) begin
				take();
			end else begin
				item.operation = OP_ALLOC;
				item.cell_width = 14'(rand_extent());
				item.cell_height = 14'(rand_extent());
				send_item(item);
			end
		end
		wait_quiet();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		rcv_stall_pct = 0;
		write_reg(CFG_MAX_SIDE, 4'd8);
		write_reg(CFG_INITIAL_SIDE, 4'd6);
		hold_len = 300;
		for (int i = 0; i < 24; i++) begin
			if (i % 6 == 5) begin
				take();
			end else begin
				alloc($urandom_range(40, 1), $urandom_range(40, 1));
			end
		end
		wait_quiet();
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("tb_shelf_atlas_allocator NOT OK");
				$finish;
			end
		end
	end

	initial begin : rsp_sink
		int unsigned hold;
		hold = 0;
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				hold = hold_len;
				hold_len = 0;
			end
			if (hold != 0) begin
				hold--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
			end
		end
	end

	initial begin : rsp_check
		rsp_t want;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && rsp_ready) begin
				if (replies_due.size() == 0) begin
					report_error("response transfer with no request outstanding");
				end else begin
					want = replies_due.pop_front();
					check_field("status", 14'(rsp.status), 14'(want.status));
					check_field("cell_x", 14'(rsp.cell_x), 14'(want.cell_x));
					check_field("cell_y", 14'(rsp.cell_y), 14'(want.cell_y));
					check_field("region_x", 14'(rsp.region_x), 14'(want.region_x));
					check_field("region_y", 14'(rsp.region_y), 14'(want.region_y));
					check_field("region_w", rsp.region_w, want.region_w);
					check_field("region_h", rsp.region_h, want.region_h);
					check_field("was_resized", 14'(rsp.was_resized),
						14'(want.was_resized));
					check_field("atlas_side", rsp.atlas_side, want.atlas_side);
					check_field("atlas_full", 14'(rsp.atlas_full),
						14'(want.atlas_full));
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		rcv_stall_pct = 0;
		hold_len = 0;
		errors = 0;
		reg_initial = CFG_INITIAL_RST;
		reg_max = CFG_MAX_RST;
		init_atlas();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_limits();
		test_random_phase(400, 20, 73);
		test_random_phase(400, 73, 20);
		test_backpressure();
		test_random_phase(400, 0, 0);

		wait_quiet();
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("tb_shelf_atlas_allocator OK");
		end else begin
			$display("tb_shelf_atlas_allocator NOT OK");
		end
		$finish;
	end

endmodule
